// ===== src/aes_pkg.sv =====
package aes_pkg;

   localparam int BlockWidth = 128;
   localparam int HalfWidth  = 64;
   localparam int NumRounds  = 10;
   localparam int KeyIndexWidth = 1;

   localparam logic [KeyIndexWidth-1:0] KEY_HIGH_INDEX = 1'b0;
   localparam logic [KeyIndexWidth-1:0] KEY_LOW_INDEX  = 1'b1;

   typedef logic [BlockWidth-1:0] block_type;

   // Forward S-box
   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tbl [256];
      tbl = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return tbl[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
   endfunction

   // Byte i of a block sits at bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

   // SubBytes and ShiftRows
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BlockWidth-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
         end
      end
      return t;
   endfunction

   function automatic block_type column_mix(input block_type s);
      block_type t;
      logic [7:0] a, b, d, e, all;
      for (int c = 0; c < 4; c++) begin
         a = get_byte(s, 4*c);
         b = get_byte(s, 4*c+1);
         d = get_byte(s, 4*c+2);
         e = get_byte(s, 4*c+3);
         all = a ^ b ^ d ^ e;
         t[BlockWidth-1-8*(4*c)   -: 8] = a ^ all ^ xtime(a ^ b);
         t[BlockWidth-1-8*(4*c+1) -: 8] = b ^ all ^ xtime(b ^ d);
         t[BlockWidth-1-8*(4*c+2) -: 8] = d ^ all ^ xtime(d ^ e);
         t[BlockWidth-1-8*(4*c+3) -: 8] = e ^ all ^ xtime(e ^ a);
      end
      return t;
   endfunction

   // One step of the key schedule
   function automatic block_type next_round_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      t = t ^ {rc, 24'h0};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [7:0] round_const(input int r);
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 1; i < r; i++) begin
         rc = xtime(rc);
      end
      return rc;
   endfunction

endpackage

// ===== src/aes_key_sched.sv =====
module aes_key_sched (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [aes_pkg::KeyIndexWidth:0] csr_index,
   input  logic [aes_pkg::HalfWidth-1:0] csr_data,
   output aes_pkg::block_type           key_bank [aes_pkg::NumRounds+1]
);
   import aes_pkg::*;

   logic [HalfWidth-1:0] key_high_ff, key_high_in;
   logic [HalfWidth-1:0] key_low_ff, key_low_in;

   assign csr_ready = !reset;

   // Capture key halves; other indexes are dropped
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_valid && csr_index[KeyIndexWidth] == 1'b0) begin
         if (csr_index[KeyIndexWidth-1:0] == KEY_HIGH_INDEX) begin
            key_high_in = csr_data;
         end
         if (csr_index[KeyIndexWidth-1:0] == KEY_LOW_INDEX) begin
            key_low_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   // Expand round keys in a registered chain, one round per cycle; round key r
   // is held in sched_ff[r], and the chain keeps running while the pipeline stalls
   block_type key_cat;
   block_type sched_ff [1:NumRounds];
   block_type sched_in [1:NumRounds];

   assign key_cat = {key_high_ff, key_low_ff};

   always_comb begin
      sched_in[1] = next_round_key(key_cat, round_const(1));
      for (int r = 2; r <= NumRounds; r++) begin
         sched_in[r] = next_round_key(sched_ff[r-1], round_const(r));
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 1; r <= NumRounds; r++) begin
         sched_ff[r] <= sched_in[r];
      end
   end

   always_comb begin
      key_bank[0] = key_cat;
      for (int r = 1; r <= NumRounds; r++) begin
         key_bank[r] = sched_ff[r];
      end
   end

endmodule

// ===== src/aes_round.sv =====
module aes_round #(
   parameter bit FinalRound = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  aes_pkg::block_type in_state,
   input  aes_pkg::block_type round_key,
   output logic               out_valid,
   output aes_pkg::block_type out_state
);
   import aes_pkg::*;

   logic      valid_ff;
   block_type state_ff, state_in;

   // Apply one round
   always_comb begin
      if (FinalRound) begin
         state_in = sub_shift(in_state) ^ round_key;
      end else begin
         state_in = column_mix(sub_shift(in_state)) ^ round_key;
      end
   end

   // Advance only when downstream moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== src/aes128_block_encrypt_core.sv =====
// AES-128 encryption core. One plaintext beat is accepted per cycle while the
// output is not stalled, and its ciphertext passes through eleven registers
// (one for the initial key add, then one per round) to the output. A
// stalled output freezes the whole pipeline. A key write takes effect for the
// very next beat, since each round key reaches its stage as the beat does;
// input is held off in any cycle with a key write offered, and keys must only
// be written while no beat is in flight.
module aes128_block_encrypt_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [aes_pkg::KeyIndexWidth:0] csr_index,
   input  logic [aes_pkg::HalfWidth-1:0] csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [aes_pkg::HalfWidth-1:0] req_block_high,
   input  logic [aes_pkg::HalfWidth-1:0] req_block_low,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [aes_pkg::HalfWidth-1:0] rsp_cipher_high,
   output logic [aes_pkg::HalfWidth-1:0] rsp_cipher_low
);
   import aes_pkg::*;

   block_type key_bank [NumRounds+1];
   logic      stage_valid [NumRounds+1];
   block_type stage_state [NumRounds+1];
   logic      enable;

   aes_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .key_bank   (key_bank)
   );

   // Whole pipe moves when the output slot is free or being drained
   assign enable    = !stage_valid[NumRounds] || rsp_ready;
   assign req_ready = enable && !csr_valid && !reset;

   // Initial key add
   logic      valid0_ff;
   block_type state0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (enable) begin
         valid0_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state0_ff <= {req_block_high, req_block_low} ^ key_bank[0];
      end
   end

   assign stage_valid[0] = valid0_ff;
   assign stage_state[0] = state0_ff;

   for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      aes_round #(.FinalRound(r == NumRounds)) u_round (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (stage_valid[r-1]),
         .in_state  (stage_state[r-1]),
         .round_key (key_bank[r]),
         .out_valid (stage_valid[r]),
         .out_state (stage_state[r])
      );
   end

   assign rsp_valid       = stage_valid[NumRounds];
   assign rsp_cipher_high = stage_state[NumRounds][BlockWidth-1:HalfWidth];
   assign rsp_cipher_low  = stage_state[NumRounds][HalfWidth-1:0];

   // Stalled result holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_high)
         && $stable(rsp_cipher_low))
      else $error("stalled result changed");

   // Input is refused only while output is stalled or a key write is offered
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready) || csr_valid)
      else $error("input refused without output stall");

   // An accepted beat reaches the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid[0])
      else $error("accepted beat lost");

endmodule

// ===== sim/aes128_block_encrypt_core_tb.sv =====
`timescale 1ns / 1ps

module aes128_block_encrypt_core_tb;
   import aes_pkg::*;

   localparam logic [KeyIndexWidth:0] HIGH_CSR    = {1'b0, KEY_HIGH_INDEX};
   localparam logic [KeyIndexWidth:0] LOW_CSR     = {1'b0, KEY_LOW_INDEX};
   localparam logic [KeyIndexWidth:0] BAD_INDEX_A = 2'd2;
   localparam logic [KeyIndexWidth:0] BAD_INDEX_B = 2'd3;
   localparam int SettleCycles = 20;
   localparam int CycleLimit   = 200000;

   typedef struct packed {
      logic [HalfWidth-1:0] hi;
      logic [HalfWidth-1:0] lo;
   } cipher_pair_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [KeyIndexWidth:0] csr_index = '0;
   logic [HalfWidth-1:0]   csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [HalfWidth-1:0]   req_block_high = '0;
   logic [HalfWidth-1:0]   req_block_low = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [HalfWidth-1:0]   rsp_cipher_high;
   logic [HalfWidth-1:0]   rsp_cipher_low;

   aes128_block_encrypt_core i_dut (.*);

   always #5 clock = ~clock;

   // Predictor state: S-box built from the field inverse, key and round keys
   logic [7:0]           sbox_lut [256];
   logic [HalfWidth-1:0] key_hi, key_lo;
   logic [127:0]         sched_keys [11];
   cipher_pair_type      expected_ciphers [$];
   int                   mismatches = 0;
   int                   blocks_sent = 0;
   int                   ciphers_seen = 0;
   int                   key_writes = 0;
   int                   cycle_count = 0;
   int                   req_idle_pct = 30;
   int                   rsp_idle_pct = 30;
   int                   rsp_hold_cycles = 0;

   function automatic logic [7:0] xt(input logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = xt(a);
      end
      return p;
   endfunction

   function automatic logic [7:0] affine_inv(input logic [7:0] x);
      logic [7:0] inv, r;
      inv = 8'h01;
      // x^254 is the multiplicative inverse, and maps zero to zero
      for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
      if (x == 8'h00) inv = 8'h00;
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      return r;
   endfunction

   function automatic void expand_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      w[0] = key_hi[63:32];
      w[1] = key_hi[31:0];
      w[2] = key_lo[63:32];
      w[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]], sbox_lut[t[15:8]],
                 sbox_lut[t[7:0]]} ^ {rc, 24'h0};
            rc = xt(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   function automatic cipher_pair_type encrypt_block(input logic [63:0] hi,
                                                     input logic [63:0] lo);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a, b, d, e, all;
      logic [127:0] blk;
      blk = {hi, lo};
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ sched_keys[0][127-8*i -: 8];
      for (int rnd = 1; rnd <= NumRounds; rnd++) begin
         // substitute and shift rows
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[r+4*c] = sbox_lut[s[r+4*((c+r)%4)]];
         s = t;
         // mix columns on all but the last round
         if (rnd != NumRounds) begin
            for (int c = 0; c < 4; c++) begin
               a = s[4*c]; b = s[4*c+1]; d = s[4*c+2]; e = s[4*c+3];
               all = a ^ b ^ d ^ e;
               s[4*c]   = a ^ all ^ xt(a ^ b);
               s[4*c+1] = b ^ all ^ xt(b ^ d);
               s[4*c+2] = d ^ all ^ xt(d ^ e);
               s[4*c+3] = e ^ all ^ xt(e ^ a);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ sched_keys[rnd][127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
      return '{hi: blk[127:64], lo: blk[63:0]};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare each cipher beat with the oldest expectation
   always @(posedge clock) begin
      cipher_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         ciphers_seen++;
         if (expected_ciphers.size() == 0) begin
            $error("cipher beat with nothing expected: %h %h", rsp_cipher_high, rsp_cipher_low);
            mismatches++;
         end else begin
            want = expected_ciphers.pop_front();
            if (rsp_cipher_high !== want.hi) begin
               $error("cipher_high expected %h actual %h", want.hi, rsp_cipher_high);
               mismatches++;
            end
            if (rsp_cipher_low !== want.lo) begin
               $error("cipher_low expected %h actual %h", want.lo, rsp_cipher_low);
               mismatches++;
            end
         end
      end
   end

   // Offer one plaintext beat, with random idle cycles ahead of it
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_block_high <= hi;
      req_block_low <= lo;
      do @(posedge clock); while (!req_ready);
      expected_ciphers.push_back(encrypt_block(hi, lo));
      blocks_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      drop_valid();
      while (expected_ciphers.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Key register write while the pipe is empty, then let the schedule settle
   task automatic write_key(input logic [KeyIndexWidth:0] idx, input logic [63:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == HIGH_CSR) key_hi = value;
      else if (idx == LOW_CSR) key_lo = value;
      if (idx == HIGH_CSR || idx == LOW_CSR) expand_schedule();
      key_writes++;
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic test_reset_key();
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000000000000000, 64'h0000000000000001);
      send_block(rand64(), rand64());
   endtask

   task automatic test_standard_vector();
      write_key(HIGH_CSR, 64'h0001020304050607);
      write_key(LOW_CSR, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '1);
   endtask

   task automatic test_ignored_index();
      write_key(BAD_INDEX_A, '1);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      write_key(BAD_INDEX_B, 64'h5a5a5a5a5a5a5a5a);
      send_block(rand64(), rand64());
   endtask

   task automatic test_mixed_key();
      // first only the high half changes and blocks run under the mixed key; later the low half changes too
      write_key(HIGH_CSR, '1);
      send_block('0, '0);
      send_block('1, '1);
      write_key(LOW_CSR, '1);
      send_block('0, '0);
      send_block('1, '0);
      write_key(HIGH_CSR, '0);
      write_key(LOW_CSR, '0);
      send_block('1, '1);
   endtask

   task automatic test_backpressure();
      // stall the result side long enough to fill the pipe and block input
      rsp_hold_cycles = 150;
      req_idle_pct = 0;
      for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
      req_idle_pct = 30;
      // pause the sender until everything has drained
      drop_valid();
      while (expected_ciphers.size() != 0) @(posedge clock);
      for (int i = 0; i < 10; i++) send_block(rand64(), rand64());
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         write_key(HIGH_CSR, rand64());
         write_key(LOW_CSR, rand64());
         // one phase runs with no idling on either side
         req_idle_pct = (phase == 2) ? 0 : 30;
         rsp_idle_pct = (phase == 2) ? 0 : 30;
         for (int i = 0; i < 90; i++) send_block(rand64(), rand64());
      end
      req_idle_pct = 30;
      rsp_idle_pct = 30;
   endtask

   initial begin
      for (int i = 0; i < 256; i++) sbox_lut[i] = affine_inv(i[7:0]);
      key_hi = '0;
      key_lo = '0;
      expand_schedule();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (SettleCycles) @(posedge clock);

      test_reset_key();
      test_standard_vector();
      test_ignored_index();
      test_mixed_key();
      test_backpressure();
      test_random_traffic();
      test_backpressure();

      wait_drained();
      $display("Covered %0d plaintext blocks and %0d cipher beats over %0d key writes,",
               blocks_sent, ciphers_seen, key_writes);
      $display("including ignored register indexes, mixed keys and long output stalls.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/aes_pkg.sv
src/aes_key_sched.sv
src/aes_round.sv
src/aes128_block_encrypt_core.sv
sim/aes128_block_encrypt_core_tb.sv
